@@ rtl/cbp_pkg.sv @@
package cbp_pkg;

    // default limits for the size registers
    localparam int unsigned DEF_MAX_WIDTH = 4096;
    localparam int unsigned DEF_MAX_PAD   = 1023;

    // configuration port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // field widths as written on the configuration port
    localparam int unsigned FMT_W     = 3;
    localparam int unsigned SIZE_IN_W = 13;
    localparam int unsigned PAD_IN_W  = 10;
    localparam int unsigned COLOR_W   = 24;

    // stream payload widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned COMP_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_BOTTOM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLOR  = 3'd7;

    // pixel format codes
    localparam logic [FMT_W-1:0] FMT_GRAY = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_BGR  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_I420 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_NV12 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_NV21 = 3'd5;

    // plane codes
    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;

    // pick one byte of the padding color, the unused fourth slot reads zero
    function automatic logic [BYTE_W-1:0] color_byte(input logic [COLOR_W-1:0] color,
                                                     input logic [COMP_W-1:0] k);
        logic [BYTE_W-1:0] b;
        unique case (k)
            2'd0:    b = color[7:0];
            2'd1:    b = color[15:8];
            2'd2:    b = color[23:16];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/cbp_cfg.sv @@
module cbp_cfg #(
    parameter int unsigned MAX_WIDTH = cbp_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_PAD   = cbp_pkg::DEF_MAX_PAD,
    localparam int unsigned IW_W  = $clog2(MAX_WIDTH + 1),
    localparam int unsigned PAD_W = $clog2(MAX_PAD + 1),
    localparam int unsigned POS_W = $clog2(MAX_WIDTH + 2 * MAX_PAD + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [cbp_pkg::FMT_W-1:0]          fmt,
    output logic [IW_W-1:0]                    in_w,
    output logic [IW_W-1:0]                    in_h,
    output logic [PAD_W-1:0]                   pad_l,
    output logic [PAD_W-1:0]                   pad_t,
    output logic [cbp_pkg::COLOR_W-1:0]        color,
    output logic [POS_W-1:0]                   out_w,
    output logic [POS_W-1:0]                   out_h,
    output logic                               geom_bad
);

    localparam int unsigned WSAT_W = (IW_W > cbp_pkg::SIZE_IN_W) ? IW_W : cbp_pkg::SIZE_IN_W;
    localparam int unsigned PSAT_W = (PAD_W > cbp_pkg::PAD_IN_W) ? PAD_W : cbp_pkg::PAD_IN_W;

    logic [cbp_pkg::FMT_W-1:0]   fmt_reg,    fmt_next;
    logic [IW_W-1:0]             in_w_reg,   in_w_next;
    logic [IW_W-1:0]             in_h_reg,   in_h_next;
    logic [PAD_W-1:0]            pad_l_reg,  pad_l_next;
    logic [PAD_W-1:0]            pad_r_reg,  pad_r_next;
    logic [PAD_W-1:0]            pad_t_reg,  pad_t_next;
    logic [PAD_W-1:0]            pad_b_reg,  pad_b_next;
    logic [cbp_pkg::COLOR_W-1:0] color_reg,  color_next;

    logic [WSAT_W-1:0] size_in;
    logic [IW_W-1:0]   size_sat;
    logic [PSAT_W-1:0] pad_in;
    logic [PAD_W-1:0]  pad_sat;
    logic              yuv;

    assign cfg_ready = 1'b1;

    // saturate sizes and paddings as they are written
    always_comb begin
        size_in = WSAT_W'(cfg_data[cbp_pkg::SIZE_IN_W-1:0]);
        pad_in  = PSAT_W'(cfg_data[cbp_pkg::PAD_IN_W-1:0]);
        if (size_in > WSAT_W'(MAX_WIDTH)) begin
            size_sat = IW_W'(MAX_WIDTH);
        end else begin
            size_sat = IW_W'(size_in);
        end
        if (pad_in > PSAT_W'(MAX_PAD)) begin
            pad_sat = PAD_W'(MAX_PAD);
        end else begin
            pad_sat = PAD_W'(pad_in);
        end
    end

    // register write decode
    always_comb begin
        fmt_next   = fmt_reg;
        in_w_next  = in_w_reg;
        in_h_next  = in_h_reg;
        pad_l_next = pad_l_reg;
        pad_r_next = pad_r_reg;
        pad_t_next = pad_t_reg;
        pad_b_next = pad_b_reg;
        color_next = color_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cbp_pkg::REG_FORMAT:     fmt_next   = cfg_data[cbp_pkg::FMT_W-1:0];
                cbp_pkg::REG_IN_WIDTH:   in_w_next  = size_sat;
                cbp_pkg::REG_IN_HEIGHT:  in_h_next  = size_sat;
                cbp_pkg::REG_PAD_LEFT:   pad_l_next = pad_sat;
                cbp_pkg::REG_PAD_RIGHT:  pad_r_next = pad_sat;
                cbp_pkg::REG_PAD_TOP:    pad_t_next = pad_sat;
                cbp_pkg::REG_PAD_BOTTOM: pad_b_next = pad_sat;
                cbp_pkg::REG_PAD_COLOR:  color_next = cfg_data[cbp_pkg::COLOR_W-1:0];
                default:                 fmt_next   = fmt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= cbp_pkg::FMT_GRAY;
            in_w_reg  <= IW_W'(1);
            in_h_reg  <= IW_W'(1);
            pad_l_reg <= '0;
            pad_r_reg <= '0;
            pad_t_reg <= '0;
            pad_b_reg <= '0;
            color_reg <= '0;
        end else begin
            fmt_reg   <= fmt_next;
            in_w_reg  <= in_w_next;
            in_h_reg  <= in_h_next;
            pad_l_reg <= pad_l_next;
            pad_r_reg <= pad_r_next;
            pad_t_reg <= pad_t_next;
            pad_b_reg <= pad_b_next;
            color_reg <= color_next;
        end
    end

    // padded frame size and geometry check
    always_comb begin
        out_w = POS_W'(in_w_reg) + POS_W'(pad_l_reg) + POS_W'(pad_r_reg);
        out_h = POS_W'(in_h_reg) + POS_W'(pad_t_reg) + POS_W'(pad_b_reg);
        yuv   = (fmt_reg >= cbp_pkg::FMT_I420);
        geom_bad = (fmt_reg > cbp_pkg::FMT_NV21) || (out_w == '0) || (out_h == '0) ||
                   (yuv && (out_w[0] || out_h[0] || pad_l_reg[0] || pad_t_reg[0]));
    end

    assign fmt   = fmt_reg;
    assign in_w  = in_w_reg;
    assign in_h  = in_h_reg;
    assign pad_l = pad_l_reg;
    assign pad_t = pad_t_reg;
    assign color = color_reg;

endmodule

@@ rtl/cbp_core.sv @@
module cbp_core #(
    parameter int unsigned MAX_WIDTH = cbp_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_PAD   = cbp_pkg::DEF_MAX_PAD,
    localparam int unsigned IW_W  = $clog2(MAX_WIDTH + 1),
    localparam int unsigned PAD_W = $clog2(MAX_PAD + 1),
    localparam int unsigned POS_W = $clog2(MAX_WIDTH + 2 * MAX_PAD + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input item
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cbp_pkg::BYTE_W-1:0]       s_tdata,
    input  logic                             s_tuser,
    // result item
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cbp_pkg::BYTE_W-1:0]       m_tdata,
    output logic [3:0]                       m_tuser,
    output logic                             m_tlast,
    // configuration
    input  logic [cbp_pkg::FMT_W-1:0]        fmt,
    input  logic [IW_W-1:0]                  in_w,
    input  logic [IW_W-1:0]                  in_h,
    input  logic [PAD_W-1:0]                 pad_l,
    input  logic [PAD_W-1:0]                 pad_t,
    input  logic [cbp_pkg::COLOR_W-1:0]      color,
    input  logic [POS_W-1:0]                 out_w,
    input  logic [POS_W-1:0]                 out_h,
    input  logic                             geom_bad
);

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic [cbp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          in_present_reg;

    // frame position
    logic [cbp_pkg::PLANE_W-1:0]   plane_reg, plane_next;
    logic [POS_W-1:0]              row_reg,   row_next;
    logic [POS_W-1:0]              col_reg,   col_next;
    logic [cbp_pkg::COMP_W-1:0]    comp_reg,  comp_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [cbp_pkg::BYTE_W-1:0]    out_byte_reg,  out_byte_next;
    logic [cbp_pkg::PLANE_W-1:0]   out_plane_reg, out_plane_next;
    logic                          out_taken_reg, out_taken_next;
    logic                          out_last_reg,  out_last_next;
    logic                          out_err_reg,   out_err_next;

    // plane geometry
    logic [cbp_pkg::PLANE_W-1:0]   num_planes;
    logic                          packed3;
    logic                          i420;
    logic [POS_W-1:0]              l_c1, l_r1;
    logic [POS_W-1:0]              ch_w, ch_h, ch_c0, ch_c1, ch_r0, ch_r1;
    logic [POS_W-1:0]              w_cur, h_cur;
    logic                          pos_ok;

    // effective position after a possible restart
    logic [cbp_pkg::PLANE_W-1:0]   plane_e;
    logic [POS_W-1:0]              row_e, col_e;
    logic [cbp_pkg::COMP_W-1:0]    comp_e;
    logic                          luma_e;
    logic [POS_W-1:0]              w_e, h_e, c0_e, c1_e, r0_e, r1_e;

    logic                          proc;
    logic                          interior;
    logic                          emit;
    logic [cbp_pkg::BYTE_W-1:0]    pad_byte;
    logic                          comp_wrap, col_wrap, row_wrap, plane_wrap;
    logic [cbp_pkg::COMP_W-1:0]    comp_sel;

    // an item moves on when the result register is free or draining
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    // luma and chroma plane bounds
    always_comb begin
        i420       = (fmt == cbp_pkg::FMT_I420);
        packed3    = (fmt == cbp_pkg::FMT_RGB) || (fmt == cbp_pkg::FMT_BGR);
        num_planes = i420 ? 2'd3 : ((fmt >= cbp_pkg::FMT_NV12) ? 2'd2 : 2'd1);
        l_c1  = POS_W'(pad_l) + POS_W'(in_w);
        l_r1  = POS_W'(pad_t) + POS_W'(in_h);
        ch_h  = out_h >> 1;
        ch_r0 = POS_W'(pad_t) >> 1;
        ch_r1 = ch_r0 + ((POS_W'(in_h) + POS_W'(1)) >> 1);
        if (i420) begin
            ch_w  = out_w >> 1;
            ch_c0 = POS_W'(pad_l) >> 1;
            ch_c1 = ch_c0 + (POS_W'(in_w) >> 1);
        end else begin
            ch_w  = out_w;
            ch_c0 = POS_W'(pad_l);
            ch_c1 = l_c1;
        end
    end

    // restart check on the stored position
    always_comb begin
        if (plane_reg == cbp_pkg::PLANE_LUMA) begin
            w_cur = out_w;
            h_cur = out_h;
        end else begin
            w_cur = ch_w;
            h_cur = ch_h;
        end
        pos_ok = (plane_reg < num_planes) && (row_reg < h_cur) && (col_reg < w_cur) &&
                 ((plane_reg == cbp_pkg::PLANE_LUMA && packed3) ? (comp_reg < 2'd3)
                                                                : (comp_reg == '0));
        if (pos_ok) begin
            plane_e = plane_reg;
            row_e   = row_reg;
            col_e   = col_reg;
            comp_e  = comp_reg;
        end else begin
            plane_e = cbp_pkg::PLANE_LUMA;
            row_e   = '0;
            col_e   = '0;
            comp_e  = '0;
        end
        luma_e = (plane_e == cbp_pkg::PLANE_LUMA);
        if (luma_e) begin
            w_e  = out_w;
            h_e  = out_h;
            c0_e = POS_W'(pad_l);
            c1_e = l_c1;
            r0_e = POS_W'(pad_t);
            r1_e = l_r1;
        end else begin
            w_e  = ch_w;
            h_e  = ch_h;
            c0_e = ch_c0;
            c1_e = ch_c1;
            r0_e = ch_r0;
            r1_e = ch_r1;
        end
    end

    // padding byte for this position
    always_comb begin
        if (luma_e) begin
            if (fmt == cbp_pkg::FMT_RGB) begin
                comp_sel = comp_e;
            end else if (fmt == cbp_pkg::FMT_BGR) begin
                comp_sel = 2'd2 - comp_e;
            end else begin
                comp_sel = 2'd0;
            end
        end else if (i420) begin
            comp_sel = plane_e;
        end else begin
            comp_sel = 2'd1 + {1'b0, col_e[0] ^ (fmt == cbp_pkg::FMT_NV21)};
        end
        pad_byte = cbp_pkg::color_byte(color, comp_sel);
    end

    // interior test and position advance
    always_comb begin
        interior = (row_e >= r0_e) && (row_e < r1_e) && (col_e >= c0_e) && (col_e < c1_e);
        emit     = geom_bad || !interior || in_present_reg;

        comp_wrap  = !(luma_e && packed3) || (comp_e == 2'd2);
        col_wrap   = comp_wrap && (col_e == w_e - POS_W'(1));
        row_wrap   = col_wrap && (row_e == h_e - POS_W'(1));
        plane_wrap = row_wrap && (plane_e == num_planes - 2'd1);

        plane_next = plane_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        comp_next  = comp_reg;
        if (proc && !geom_bad) begin
            if (!emit) begin
                // waiting for a sample, but a restart still takes effect
                plane_next = plane_e;
                row_next   = row_e;
                col_next   = col_e;
                comp_next  = comp_e;
            end else begin
                comp_next  = comp_wrap ? '0 : comp_e + 2'd1;
                col_next   = comp_wrap ? (col_wrap ? '0 : col_e + POS_W'(1)) : col_e;
                row_next   = col_wrap ? (row_wrap ? '0 : row_e + POS_W'(1)) : row_e;
                plane_next = row_wrap ? (plane_wrap ? cbp_pkg::PLANE_LUMA : plane_e + 2'd1)
                                      : plane_e;
            end
        end
    end

    // result register load and drain
    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_plane_next = out_plane_reg;
        out_taken_next = out_taken_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (proc) begin
            out_valid_next = emit;
            if (geom_bad) begin
                out_byte_next  = '0;
                out_plane_next = cbp_pkg::PLANE_LUMA;
                out_taken_next = 1'b0;
                out_last_next  = 1'b0;
                out_err_next   = 1'b1;
            end else begin
                out_byte_next  = interior ? in_byte_reg : pad_byte;
                out_plane_next = plane_e;
                out_taken_next = interior;
                out_last_next  = plane_wrap;
                out_err_next   = 1'b0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            plane_reg     <= cbp_pkg::PLANE_LUMA;
            row_reg       <= '0;
            col_reg       <= '0;
            comp_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            comp_reg      <= comp_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
        end
        out_byte_reg  <= out_byte_next;
        out_plane_reg <= out_plane_next;
        out_taken_reg <= out_taken_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_taken_reg, out_plane_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/constant_border_pixel_padder.sv @@
// Constant border padder for 8-bit image streams.
// Input channel (s_): one image byte per item in plane-sequential raster
// order; s_tuser marks that s_tdata holds a real byte.
// Result channel (m_): the padded frame, one byte per item, luma or packed
// plane first, then the chroma plane(s). m_tlast marks the frame's last
// byte; m_tuser carries the plane, a flag that the offered byte was used
// and a flag for an invalid geometry.
// Every input item is one step: a border position emits the padding byte
// (and drops any offered byte), an interior position passes the offered byte
// or emits nothing while none is offered; a bad geometry emits an error item.
// Configuration writes (cfg_) are taken at once and must come while the
// block is idle.
// The accepted item is held in the input register, then its result in the
// result register. Throughput: one item per cycle while m_tready is high,
// bound by the single-step position update between the two registers.
// Reset clears both registers and returns to the start of a frame with the
// default geometry (gray, 1x1, no padding). When m_tready is low the result
// register holds, the input register fills, and then s_tready drops.
module constant_border_pixel_padder #(
    parameter int unsigned MAX_WIDTH = cbp_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_PAD   = cbp_pkg::DEF_MAX_PAD
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cbp_pkg::BYTE_W-1:0]      s_tdata,   // sample
    input  logic                            s_tuser,   // sample_present
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cbp_pkg::BYTE_W-1:0]      m_tdata,   // out_byte
    output logic [3:0]                      m_tuser,   // plane[1:0], sample_taken, geometry_error
    output logic                            m_tlast,   // frame_last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned IW_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned PAD_W = $clog2(MAX_PAD + 1);
    localparam int unsigned POS_W = $clog2(MAX_WIDTH + 2 * MAX_PAD + 1);

    logic [cbp_pkg::FMT_W-1:0]   fmt;
    logic [IW_W-1:0]             in_w;
    logic [IW_W-1:0]             in_h;
    logic [PAD_W-1:0]            pad_l;
    logic [PAD_W-1:0]            pad_t;
    logic [cbp_pkg::COLOR_W-1:0] color;
    logic [POS_W-1:0]            out_w;
    logic [POS_W-1:0]            out_h;
    logic                        geom_bad;

    // configuration registers and frame geometry
    cbp_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_PAD   (MAX_PAD)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fmt       (fmt),
        .in_w      (in_w),
        .in_h      (in_h),
        .pad_l     (pad_l),
        .pad_t     (pad_t),
        .color     (color),
        .out_w     (out_w),
        .out_h     (out_h),
        .geom_bad  (geom_bad)
    );

    // position tracking and byte selection
    cbp_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_PAD   (MAX_PAD)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fmt       (fmt),
        .in_w      (in_w),
        .in_h      (in_h),
        .pad_l     (pad_l),
        .pad_t     (pad_t),
        .color     (color),
        .out_w     (out_w),
        .out_h     (out_h),
        .geom_bad  (geom_bad)
    );

endmodule

@@ bench/constant_border_pixel_padder_tb.sv @@
`timescale 1ns / 100ps

module constant_border_pixel_padder_tb;

    // format codes the block must reject
    localparam logic [cbp_pkg::FMT_W-1:0] FMT_RSVD_6 = 3'd6;
    localparam logic [cbp_pkg::FMT_W-1:0] FMT_RSVD_7 = 3'd7;

    localparam int ITEM_TARGET  = 1700;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_TICKS = 4;

    typedef struct packed {
        logic [cbp_pkg::BYTE_W-1:0] sample;
        logic                       present;
    } pixel_in_t;

    typedef struct packed {
        logic [cbp_pkg::BYTE_W-1:0]  data;
        logic [cbp_pkg::PLANE_W-1:0] plane;
        logic                        taken;
        logic                        last;
        logic                        err;
    } padded_byte_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [cbp_pkg::BYTE_W-1:0]     s_tdata   = '0;   // sample
    logic                           s_tuser   = 1'b0; // sample_present
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [cbp_pkg::BYTE_W-1:0]     m_tdata;          // out_byte
    logic [3:0]                     m_tuser;          // plane[1:0], sample_taken, geometry_error
    logic                           m_tlast;          // frame_last
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    constant_border_pixel_padder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_in_t    pixel_backlog[$];
    padded_byte_t expected_bytes[$];
    int           items_queued   = 0;
    int           items_accepted = 0;
    int           error_count    = 0;
    int           long_hold_req  = 0;
    logic         in_acc         = 1'b0;

    // predicted configuration
    logic [cbp_pkg::FMT_W-1:0]   cur_format;
    int unsigned                 cur_in_w, cur_in_h;
    int unsigned                 cur_left, cur_right, cur_top, cur_bottom;
    logic [cbp_pkg::COLOR_W-1:0] cur_color;

    // predicted scan position
    int unsigned at_plane, at_row, at_col, at_comp;

    function automatic int unsigned sat_value(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // extent and interior window of one plane
    function automatic void plane_bounds(input int unsigned pl,
                                         output int unsigned w, h, c0, c1, r0, r1, nel);
        int unsigned ow, oh;
        ow = cur_in_w + cur_left + cur_right;
        oh = cur_in_h + cur_top + cur_bottom;
        if (pl == cbp_pkg::PLANE_LUMA) begin
            w   = ow;
            h   = oh;
            c0  = cur_left;
            c1  = cur_left + cur_in_w;
            r0  = cur_top;
            r1  = cur_top + cur_in_h;
            nel = (cur_format == cbp_pkg::FMT_RGB || cur_format == cbp_pkg::FMT_BGR) ? 3 : 1;
        end else begin
            nel = 1;
            h   = oh / 2;
            r0  = cur_top / 2;
            r1  = r0 + (cur_in_h + 1) / 2;
            if (cur_format == cbp_pkg::FMT_I420) begin
                w  = ow / 2;
                c0 = cur_left / 2;
                c1 = c0 + cur_in_w / 2;
            end else begin
                w  = ow;
                c0 = cur_left;
                c1 = cur_left + cur_in_w;
            end
        end
    endfunction

    function automatic void restart_frame();
        at_plane = 0;
        at_row   = 0;
        at_col   = 0;
        at_comp  = 0;
    endfunction

    // register write as the block stores it
    function automatic void store_register(input logic [cbp_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [cbp_pkg::CFG_DATA_W-1:0] val);
        unique case (idx)
            cbp_pkg::REG_FORMAT:     cur_format = val[cbp_pkg::FMT_W-1:0];
            cbp_pkg::REG_IN_WIDTH:   cur_in_w   = sat_value(32'(val[cbp_pkg::SIZE_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_WIDTH);
            cbp_pkg::REG_IN_HEIGHT:  cur_in_h   = sat_value(32'(val[cbp_pkg::SIZE_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_WIDTH);
            cbp_pkg::REG_PAD_LEFT:   cur_left   = sat_value(32'(val[cbp_pkg::PAD_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_PAD);
            cbp_pkg::REG_PAD_RIGHT:  cur_right  = sat_value(32'(val[cbp_pkg::PAD_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_PAD);
            cbp_pkg::REG_PAD_TOP:    cur_top    = sat_value(32'(val[cbp_pkg::PAD_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_PAD);
            cbp_pkg::REG_PAD_BOTTOM: cur_bottom = sat_value(32'(val[cbp_pkg::PAD_IN_W-1:0]),
                                                            cbp_pkg::DEF_MAX_PAD);
            cbp_pkg::REG_PAD_COLOR:  cur_color  = val[cbp_pkg::COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // one padder step: queue the byte it emits, if any
    function automatic void advance_padder(input pixel_in_t px);
        int unsigned  ow, oh, nplanes, w, h, c0, c1, r0, r1, nel, sel;
        logic         inner;
        padded_byte_t res;
        res = '0;
        ow  = cur_in_w + cur_left + cur_right;
        oh  = cur_in_h + cur_top + cur_bottom;
        if (cur_format > cbp_pkg::FMT_NV21 || ow == 0 || oh == 0 ||
            (cur_format >= cbp_pkg::FMT_I420 &&
             ((ow | oh | cur_left | cur_top) & 1) != 0)) begin
            res.err = 1'b1;
            expected_bytes.push_back(res);
            return;
        end
        nplanes = (cur_format == cbp_pkg::FMT_I420) ? 3 :
                  ((cur_format >= cbp_pkg::FMT_NV12) ? 2 : 1);
        if (at_plane >= nplanes)
            restart_frame();
        plane_bounds(at_plane, w, h, c0, c1, r0, r1, nel);
        // registers moved the frame out from under the position
        if (at_row >= h || at_col >= w || at_comp >= nel) begin
            restart_frame();
            plane_bounds(at_plane, w, h, c0, c1, r0, r1, nel);
        end

        // which color byte pads this position
        if (at_plane == cbp_pkg::PLANE_LUMA) begin
            if (cur_format == cbp_pkg::FMT_RGB)
                sel = at_comp;
            else if (cur_format == cbp_pkg::FMT_BGR)
                sel = 2 - at_comp;
            else
                sel = 0;
        end else if (cur_format == cbp_pkg::FMT_I420) begin
            sel = at_plane;
        end else begin
            sel = 1 + ((at_col & 1) ^ ((cur_format == cbp_pkg::FMT_NV21) ? 1 : 0));
        end

        inner = at_row >= r0 && at_row < r1 && at_col >= c0 && at_col < c1;
        if (inner && !px.present)
            return;
        res.data  = inner ? px.sample : cur_color[8*sel +: 8];
        res.taken = inner;
        res.plane = at_plane[cbp_pkg::PLANE_W-1:0];

        // step through component, column, row, plane
        at_comp = at_comp + 1;
        if (at_comp >= nel) begin
            at_comp = 0;
            at_col  = at_col + 1;
            if (at_col >= w) begin
                at_col = 0;
                at_row = at_row + 1;
                if (at_row >= h) begin
                    at_row   = 0;
                    at_plane = at_plane + 1;
                    if (at_plane >= nplanes) begin
                        at_plane = 0;
                        res.last = 1'b1;
                    end
                end
            end
        end
        expected_bytes.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    // predictor update and result check at each rising edge
    always @(posedge aclk) begin
        padded_byte_t want;
        in_acc <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            cur_format = cbp_pkg::FMT_GRAY;
            cur_in_w   = 1;
            cur_in_h   = 1;
            cur_left   = 0;
            cur_right  = 0;
            cur_top    = 0;
            cur_bottom = 0;
            cur_color  = '0;
            restart_frame();
        end else begin
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                advance_padder('{sample: s_tdata, present: s_tuser});
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    flag_mismatch("unexpected item", int'(m_tdata), 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                        flag_mismatch("out_byte", int'(m_tdata), int'(want.data));
                    if (m_tuser[1:0] !== want.plane)
                        flag_mismatch("plane", int'(m_tuser[1:0]), int'(want.plane));
                    if (m_tuser[2] !== want.taken)
                        flag_mismatch("sample_taken", int'(m_tuser[2]), int'(want.taken));
                    if (m_tlast !== want.last)
                        flag_mismatch("frame_last", int'(m_tlast), int'(want.last));
                    if (m_tuser[3] !== want.err)
                        flag_mismatch("geometry_error", int'(m_tuser[3]), int'(want.err));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("constant_border_pixel_padder_tb: done, errors");
            $finish;
        end
    end

    // input driver: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge aclk) begin
        pixel_in_t px;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_acc) begin
            // item still waiting for the block
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (pixel_backlog.size() == 0) begin
            s_tvalid <= 1'b0;
        end else begin
            px = pixel_backlog.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= px.sample;
            s_tuser  <= px.present;
            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(60, 200);
                gap_left   = 0;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap_left   = $urandom_range(0, 7);
            end
        end
    end

    // output stall pattern, with an occasional long hold-off
    rx_mode_t rx_mode     = RX_OPEN;
    int       mode_left   = 0;
    int       hold_left   = 0;
    int       holds_taken = 0;
    int       rx_tick     = 0;
    always @(negedge aclk) begin
        rx_tick++;
        if (holds_taken != long_hold_req) begin
            holds_taken = long_hold_req;
            hold_left   = LONG_HOLD;
        end
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            unique case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                RX_COMB:   m_tready <= (rx_tick % 3) != 0;
            endcase
        end
    end

    task automatic queue_pixel(input logic [cbp_pkg::BYTE_W-1:0] smp, input logic present);
        pixel_backlog.push_back('{sample: smp, present: present});
        items_queued++;
    endtask

    // random bytes, mostly offered
    task automatic queue_random(input int n);
        int          k;
        int unsigned rnd;
        for (k = 0; k < n; k++) begin
            rnd = $urandom_range(0, 255);
            queue_pixel(rnd[cbp_pkg::BYTE_W-1:0], $urandom_range(0, 6) != 0);
        end
    endtask

    // wait until every item is in and every byte out, then let the pipe settle
    task automatic drain();
        while (items_accepted != items_queued || expected_bytes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    // write all eight registers
    task automatic load_geometry(input int unsigned fmt, iw, ih, pl, pr, pt, pb,
                                 input int unsigned color);
        int unsigned vals [0:7];
        int k;
        vals[cbp_pkg::REG_FORMAT]     = fmt;
        vals[cbp_pkg::REG_IN_WIDTH]   = iw;
        vals[cbp_pkg::REG_IN_HEIGHT]  = ih;
        vals[cbp_pkg::REG_PAD_LEFT]   = pl;
        vals[cbp_pkg::REG_PAD_RIGHT]  = pr;
        vals[cbp_pkg::REG_PAD_TOP]    = pt;
        vals[cbp_pkg::REG_PAD_BOTTOM] = pb;
        vals[cbp_pkg::REG_PAD_COLOR]  = color;
        for (k = 0; k < 8; k++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= k[cbp_pkg::CFG_IDX_W-1:0];
            cfg_data  <= vals[k[cbp_pkg::CFG_IDX_W-1:0]][cbp_pkg::CFG_DATA_W-1:0];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        int          phase, n, half;
        int unsigned fmt, iw, ih, pl, pr, pt, pb, ow, oh, flen;
        logic        bad, held, paused;
        phase  = 0;
        held   = 1'b0;
        paused = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // gray with left and bottom border, idle interior step, extreme bytes
        load_geometry(32'(cbp_pkg::FMT_GRAY), 2, 1, 1, 0, 0, 1, 'h0000FF);
        queue_pixel(8'h5A, 1'b1);
        queue_pixel(8'h00, 1'b1);
        queue_pixel(8'h11, 1'b0);
        queue_pixel(8'hFF, 1'b1);
        queue_pixel(8'h80, 1'b0);
        queue_pixel(8'h3C, 1'b1);
        queue_pixel(8'hC3, 1'b0);
        drain();

        // bgr border swaps the color bytes
        load_geometry(32'(cbp_pkg::FMT_BGR), 1, 1, 1, 0, 0, 0, 'h332211);
        queue_random(6);
        drain();

        // reserved format codes
        load_geometry(32'(FMT_RSVD_6), 2, 2, 0, 0, 0, 0, 'h123456);
        queue_random(1);
        drain();
        load_geometry(32'(FMT_RSVD_7), 2, 2, 0, 0, 0, 0, 'h123456);
        queue_random(1);
        drain();

        // zero output width
        load_geometry(32'(cbp_pkg::FMT_GRAY), 0, 1, 0, 0, 0, 0, 'hABCDEF);
        queue_random(1);
        drain();

        // yuv with odd left padding
        load_geometry(32'(cbp_pkg::FMT_I420), 2, 2, 1, 1, 0, 0, 'h804020);
        queue_random(1);
        drain();

        // oversize writes saturate, maximum borders, all-ones color
        load_geometry(32'(cbp_pkg::FMT_RGB), 'h001FFF, 'hFFFFFF, 'h0003FF, 'h0003FF,
                      'hFFFFFF, 'h0003FF, 'hFFFFFF);
        queue_random(3);
        drain();

        // nv21 with an empty interior: all border, chroma bytes swapped
        load_geometry(32'(cbp_pkg::FMT_NV21), 0, 1, 2, 0, 0, 1, 'hC35A0F);
        queue_random(6);
        drain();

        // random frames, small geometries so frames wrap often
        while (items_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                fmt = $urandom_range(0, 1) ? 32'(FMT_RSVD_6) : 32'(FMT_RSVD_7);
            else
                fmt = $urandom_range(cbp_pkg::FMT_GRAY, cbp_pkg::FMT_NV21);
            iw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            ih = $urandom_range(1, 5);
            pl = $urandom_range(0, 3);
            pr = $urandom_range(0, 3);
            pt = $urandom_range(0, 3);
            pb = $urandom_range(0, 3);
            // yuv mostly legal: even left/top and even totals
            if (fmt >= cbp_pkg::FMT_I420 && fmt <= cbp_pkg::FMT_NV21 &&
                $urandom_range(0, 9) != 0) begin
                pl = pl & ~1;
                pt = pt & ~1;
                if (((iw + pl + pr) & 1) != 0)
                    pr++;
                if (((ih + pt + pb) & 1) != 0)
                    pb++;
            end
            load_geometry(fmt, iw, ih, pl, pr, pt, pb, $urandom_range(0, 'hFFFFFF));

            ow = iw + pl + pr;
            oh = ih + pt + pb;
            if (fmt == cbp_pkg::FMT_I420)
                flen = ow * oh + 2 * (ow / 2) * (oh / 2);
            else if (fmt >= cbp_pkg::FMT_NV12)
                flen = ow * oh + ow * (oh / 2);
            else if (fmt == cbp_pkg::FMT_GRAY)
                flen = ow * oh;
            else
                flen = 3 * ow * oh;
            bad = fmt > cbp_pkg::FMT_NV21 || ow == 0 ||
                  (fmt >= cbp_pkg::FMT_I420 && ((ow | oh | pl | pt) & 1) != 0);
            n = bad ? $urandom_range(1, 4) : flen + $urandom_range(0, 2 * flen);
            // keep the run near its item budget
            if (items_queued + n > ITEM_TARGET)
                n = ITEM_TARGET - items_queued;

            // receiver goes quiet while the sender keeps offering
            if (!bad && n > 20 && (!held || phase % 4 == 1)) begin
                long_hold_req++;
                held = 1'b1;
            end
            // sender pauses mid-frame until the block is empty
            if (!bad && n > 20 && (!paused || phase % 5 == 2)) begin
                half = n / 2;
                queue_random(half);
                drain();
                queue_random(n - half);
                paused = 1'b1;
            end else begin
                queue_random(n);
            end
            drain();
            phase++;
        end

        if (error_count == 0)
            $display("constant_border_pixel_padder_tb: done, clean");
        else
            $display("constant_border_pixel_padder_tb: done, errors");
        $finish;
    end

endmodule

@@ constant_border_pixel_padder.f @@
rtl/cbp_pkg.sv
rtl/cbp_cfg.sv
rtl/cbp_core.sv
rtl/constant_border_pixel_padder.sv
bench/constant_border_pixel_padder_tb.sv
